// ===== design/tasi_pkg.sv =====
`default_nettype none

package tasi_pkg;

    localparam int POSITION_BITS = 16;
    localparam int DELTA_W       = 16;
    localparam int MAG_W         = DELTA_W + 1;
    localparam int CMP_W         = (POSITION_BITS > MAG_W) ? POSITION_BITS : MAG_W;
    localparam int PROD_W        = 2 * POSITION_BITS;
    localparam int SUM_W         = PROD_W + 1;
    localparam int ROOT_STEPS    = (SUM_W + 1) / 2;
    localparam int PC_W          = 3;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [SUM_W-1:0] ROOT_BIT_INIT = SUM_W'(1) << (2 * (ROOT_STEPS - 1));

    // micro-operations
    localparam logic [2:0] OP_WAIT = 3'd0;
    localparam logic [2:0] OP_SQX  = 3'd1;
    localparam logic [2:0] OP_SQY  = 3'd2;
    localparam logic [2:0] OP_ROOT = 3'd3;
    localparam logic [2:0] OP_STEP = 3'd4;

    // jump conditions: jump to target when true, else fall through
    localparam logic [1:0] JC_NEVER     = 2'd0;
    localparam logic [1:0] JC_ALWAYS    = 2'd1;
    localparam logic [1:0] JC_NO_START  = 2'd2;
    localparam logic [1:0] JC_ROOT_MORE = 2'd3;

    // program addresses
    localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
    localparam logic [PC_W-1:0] PC_SQX  = 3'd1;
    localparam logic [PC_W-1:0] PC_SQY  = 3'd2;
    localparam logic [PC_W-1:0] PC_ROOT = 3'd3;
    localparam logic [PC_W-1:0] PC_STEP = 3'd4;

    typedef struct packed {
        logic [2:0]      op;
        logic [1:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_WAIT: w = '{op: OP_WAIT, cond: JC_NO_START,  target: PC_WAIT};
            PC_SQX:  w = '{op: OP_SQX,  cond: JC_NEVER,     target: PC_WAIT};
            PC_SQY:  w = '{op: OP_SQY,  cond: JC_NEVER,     target: PC_WAIT};
            PC_ROOT: w = '{op: OP_ROOT, cond: JC_ROOT_MORE, target: PC_ROOT};
            PC_STEP: w = '{op: OP_STEP, cond: JC_ALWAYS,    target: PC_WAIT};
            default: w = '{op: OP_WAIT, cond: JC_ALWAYS,    target: PC_WAIT};
        endcase
        return w;
    endfunction

    // absolute value of a signed delta, saturated to the count width
    function automatic logic [POSITION_BITS-1:0] magnitude(input logic [DELTA_W-1:0] d);
        logic [MAG_W-1:0] m;
        logic [CMP_W-1:0] mw;
        m = d[DELTA_W-1] ? (MAG_W'(0) - {d[DELTA_W-1], d}) : {1'b0, d};
        mw = CMP_W'(m);
        if (mw > CMP_W'(POS_MAX))
            return POS_MAX;
        else
            return POSITION_BITS'(mw);
    endfunction

endpackage

`default_nettype wire

// ===== design/two_axis_step_interpolator_core.sv =====
`default_nettype none

// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_stall  | action, delta_x, delta_y
// out      | out_valid / out_stall| step_x, step_y, dir_x, dir_y, dir_z, busy_res,
//          |                      | done_res, rejected
//
// A load, or a tick with no move running, is registered as a result in the cycle after its transfer.
// A tick on a running move passes the X square, Y square, square root and step states in order;
// the square root unit retires one result bit per cycle over ROOT_STEPS states, and step waits on a held result.
// rst_n clears the counts and sets the Y direction level; the program restarts.
// A held result blocks the next transfer on the input side.

module two_axis_step_interpolator_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          action,
    input  wire logic signed [tasi_pkg::DELTA_W-1:0] delta_x,
    input  wire logic signed [tasi_pkg::DELTA_W-1:0] delta_y,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               step_x,
    output logic                               step_y,
    output logic                               dir_x,
    output logic                               dir_y,
    output logic                               dir_z,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               rejected
);

    logic [tasi_pkg::PC_W-1:0]          pc_reg, pc_next;
    logic [tasi_pkg::POSITION_BITS-1:0] rx_reg, rx_next;
    logic [tasi_pkg::POSITION_BITS-1:0] ry_reg, ry_next;
    logic                               dx_reg, dx_next;
    logic                               dy_reg, dy_next;
    logic [tasi_pkg::SUM_W-1:0]         sum_reg, sum_next;
    logic [tasi_pkg::SUM_W-1:0]         res_reg, res_next;
    logic [tasi_pkg::SUM_W-1:0]         bit_reg, bit_next;

    logic out_valid_reg, out_valid_next;
    logic step_x_reg, step_x_next;
    logic step_y_reg, step_y_next;
    logic dir_x_reg, dir_x_next;
    logic dir_y_reg, dir_y_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic rej_reg, rej_next;

    tasi_pkg::ctrl_word_t              cw;
    logic                               out_blocked;
    logic                               accept;
    logic                               moving;
    logic                               start;
    logic                               jump;
    logic                               hold;
    logic [tasi_pkg::POSITION_BITS-1:0] mul_a;
    logic [tasi_pkg::PROD_W-1:0]        prod;
    logic [tasi_pkg::SUM_W-1:0]         trial;
    logic [tasi_pkg::SUM_W-1:0]         twice_x;
    logic [tasi_pkg::SUM_W-1:0]         twice_y;
    logic                               sx;
    logic                               sy;
    logic [tasi_pkg::POSITION_BITS-1:0] rx_dec;
    logic [tasi_pkg::POSITION_BITS-1:0] ry_dec;

    assign cw          = tasi_pkg::ucode_rom(pc_reg);
    assign out_blocked = out_valid_reg && out_stall;
    assign in_stall    = (cw.op != tasi_pkg::OP_WAIT) || out_blocked;
    assign accept      = in_valid && !in_stall;
    assign moving      = (rx_reg != '0) || (ry_reg != '0);
    assign start       = accept && action && moving;
    assign hold        = (cw.op == tasi_pkg::OP_STEP) && out_blocked;

    // shared squaring multiplier
    assign mul_a = (cw.op == tasi_pkg::OP_SQY) ? ry_reg : rx_reg;
    assign prod  = mul_a * mul_a;
    assign trial = res_reg + bit_reg;

    assign twice_x = tasi_pkg::SUM_W'({rx_reg, 1'b0});
    assign twice_y = tasi_pkg::SUM_W'({ry_reg, 1'b0});
    assign sx      = (twice_x >= res_reg) && (rx_reg != '0);
    assign sy      = (twice_y >= res_reg) && (ry_reg != '0);
    assign rx_dec  = sx ? rx_reg - 1'b1 : rx_reg;
    assign ry_dec  = sy ? ry_reg - 1'b1 : ry_reg;

    always_comb
    begin
        case (cw.cond)
            tasi_pkg::JC_NEVER:     jump = 1'b0;
            tasi_pkg::JC_ALWAYS:    jump = 1'b1;
            tasi_pkg::JC_NO_START:  jump = !start;
            tasi_pkg::JC_ROOT_MORE: jump = !bit_reg[0];
            default:                jump = 1'b1;
        endcase

        if (hold)
            pc_next = pc_reg;
        else if (jump)
            pc_next = cw.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_comb
    begin
        rx_next  = rx_reg;
        ry_next  = ry_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        sum_next = sum_reg;
        res_next = res_reg;
        bit_next = bit_reg;

        out_valid_next = out_valid_reg && out_stall;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        dir_x_next     = dir_x_reg;
        dir_y_next     = dir_y_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        rej_next       = rej_reg;

        case (cw.op)
            tasi_pkg::OP_WAIT:
            begin
                // loads and idle ticks answer at once; a live tick runs the program
                if (accept && !start)
                begin
                    out_valid_next = 1'b1;
                    step_x_next    = 1'b0;
                    step_y_next    = 1'b0;
                    done_next      = 1'b0;
                    rej_next       = 1'b0;
                    busy_next      = moving;
                    dir_x_next     = dx_reg;
                    dir_y_next     = dy_reg;
                    if (!action && moving)
                    begin
                        rej_next = 1'b1;
                    end
                    else if (!action)
                    begin
                        rx_next    = tasi_pkg::magnitude(delta_x);
                        ry_next    = tasi_pkg::magnitude(delta_y);
                        dx_next    = !delta_x[tasi_pkg::DELTA_W-1] && (delta_x != '0);
                        dy_next    = !delta_y[tasi_pkg::DELTA_W-1] && (delta_y != '0);
                        busy_next  = (delta_x != '0) || (delta_y != '0);
                        dir_x_next = dx_next;
                        dir_y_next = dy_next;
                    end
                end
            end
            tasi_pkg::OP_SQX:
            begin
                sum_next = tasi_pkg::SUM_W'(prod);
                res_next = '0;
                bit_next = tasi_pkg::ROOT_BIT_INIT;
            end
            tasi_pkg::OP_SQY:
            begin
                sum_next = sum_reg + tasi_pkg::SUM_W'(prod);
            end
            tasi_pkg::OP_ROOT:
            begin
                if (sum_reg >= trial)
                begin
                    sum_next = sum_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            tasi_pkg::OP_STEP:
            begin
                if (!out_blocked)
                begin
                    rx_next        = rx_dec;
                    ry_next        = ry_dec;
                    out_valid_next = 1'b1;
                    step_x_next    = sx;
                    step_y_next    = sy;
                    dir_x_next     = dx_reg;
                    dir_y_next     = dy_reg;
                    busy_next      = (rx_dec != '0) || (ry_dec != '0);
                    done_next      = (rx_dec == '0) && (ry_dec == '0);
                    rej_next       = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= tasi_pkg::PC_WAIT;
            rx_reg        <= '0;
            ry_reg        <= '0;
            dx_reg        <= 1'b0;
            dy_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            rx_reg        <= rx_next;
            ry_reg        <= ry_next;
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        dir_x_reg  <= dir_x_next;
        dir_y_reg  <= dir_y_next;
        busy_reg   <= busy_next;
        done_reg   <= done_next;
        rej_reg    <= rej_next;
    end

    assign out_valid = out_valid_reg;
    assign step_x    = step_x_reg;
    assign step_y    = step_y_reg;
    assign dir_x     = dir_x_reg;
    assign dir_y     = dir_y_reg;
    assign dir_z     = !dir_y_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign rejected  = rej_reg;

endmodule

`default_nettype wire
